// ----- design/erasure_burst_parameter_estimator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Erasure burst parameter estimator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ERASURE_BURST_PARAMETER_ESTIMATOR_UNIT_DEFINES_SVH
`define ERASURE_BURST_PARAMETER_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EBPE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define EBPE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ebpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Erasure burst parameter estimator package
// Shared widths, codes, sequencer states and operand helpers.
// ----------------------------------------------------------------------------
package ebpe_pkg;

   localparam int WINDOW_SLOTS_DEF = 12;
   localparam int SEQ_W            = 32;
   localparam int VAL_W            = 4;
   localparam int CNT_W            = 5;
   localparam int OP_W             = 8;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;
   localparam logic [VAL_W-1:0] VAL_MAX = 4'd15;

   typedef enum logic [0:0] {
      REG_WINDOW_T     = 1'b0,
      REG_ADAPTIVE_MDS = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SHIFT,
      ST_STATS,
      ST_UPD,
      ST_LIMIT,
      ST_BEST,
      ST_MDS,
      ST_FINISH
   } state_type;

   typedef logic signed [OP_W-1:0]   op_type;
   typedef logic signed [2*OP_W-1:0] prod_type;

   // Small unsigned count as a signed multiplier operand.
   function automatic op_type op_of(input logic [CNT_W-1:0] v);
      return op_type'({{(OP_W-CNT_W){1'b0}}, v});
   endfunction

endpackage

// ----- design/ebpe_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one packet or reset-window transaction.
// ----------------------------------------------------------------------------
interface ebpe_req_if import ebpe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             func;
   logic [SEQ_W-1:0] seq_number;

   modport source (output valid, output func, output seq_number, input ready);
   modport sink   (input valid, input func, input seq_number, output ready);
endinterface

// ----- design/ebpe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one estimate transaction.
// ----------------------------------------------------------------------------
interface ebpe_rsp_if import ebpe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             accepted;
   logic [VAL_W-1:0] best_burst;
   logic [VAL_W-1:0] best_loss;
   logic [VAL_W-1:0] work_burst;
   logic [VAL_W-1:0] work_loss;

   modport source (output valid, output accepted, output best_burst, output best_loss,
                   output work_burst, output work_loss, input ready);
   modport sink   (input valid, input accepted, input best_burst, input best_loss,
                   input work_burst, input work_loss, output ready);
endinterface

// ----- design/erasure_burst_parameter_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// Erasure burst parameter estimator
// Length: window steps plus MDS passes; a packet with no gap runs one window
// step, a gap of T+1 or more T+2 steps, MDS one pass per raise of the loss value.
// One transaction at a time; synchronous active-high reset clears control state.
// ----------------------------------------------------------------------------
`include "erasure_burst_parameter_estimator_unit_defines.svh"

// The block is a small sequencer around one shared cross-multiply comparator.
// Every rate comparison of the estimator has the form a*b against c*d, so a
// single pair of narrow signed multipliers and one compare serve all of them:
// the per-window update, the limit against the largest count, the best-pair
// selection and every pass of the MDS raise loop. The length of a
// transaction is set by the number of window steps (the clamped gap plus one)
// and by the MDS loop, which uses the comparator once per pass.
//
// Sequence of a packet transaction:
//   PREP   check order, clamp the gap, load the step counter.
//   SHIFT  shift one erasure bit (1 for a skipped number, 0 last) into slot 0.
//   STATS  count erasures and their span over slots 0..T; skip the update when
//          the window is all clear or all erased.
//   UPD    span rule or rate comparison on the working pair.
//   LIMIT  comparison against the largest count seen; write the working pair.
//   BEST   keep the working pair as the best pair when its rate is no worse.
//   MDS    adaptive mode only: raise the loss value until the rate holds.
//   FINISH hand the result to the output register.
// A reset-window transaction records the working pair as the best pair,
// clears the window and the estimates in PREP, then runs MDS if enabled.
// The output register lets a new transaction be accepted while the previous
// result still waits on the response channel.
module erasure_burst_parameter_estimator_unit import ebpe_pkg::*; #(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ebpe_req_if.sink               req_if,
   ebpe_rsp_if.source             rsp_if,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   // The effective delay is capped so that the window always fits its slots.
   localparam int               T_CAP_I = (WINDOW_SLOTS - 1 > 15) ? 15 : WINDOW_SLOTS - 1;
   localparam logic [VAL_W-1:0] T_CAP   = VAL_W'(T_CAP_I);

   // Configuration registers.
   logic [VAL_W-1:0] window_t_ff, window_t_in;
   logic             adaptive_ff, adaptive_in;

   // Control and estimator state.
   state_type               state_ff, state_in;
   logic                    started_ff, started_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WINDOW_SLOTS-1:0] win_ff, win_in;
   logic [VAL_W-1:0]        burst_est_ff, burst_est_in;
   logic [VAL_W-1:0]        loss_est_ff, loss_est_in;
   logic [VAL_W-1:0]        max_loss_ff, max_loss_in;
   logic [VAL_W-1:0]        best_burst_ff, best_burst_in;
   logic [VAL_W-1:0]        best_loss_ff, best_loss_in;
   logic [SEQ_W-1:0]        last_seq_ff, last_seq_in;

   // Per-transaction working values.
   logic             func_ff, func_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic             acc_ff, acc_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [CNT_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] span_ff, span_in;
   logic [VAL_W-1:0] wb_ff, wb_in;
   logic [VAL_W-1:0] wn_ff, wn_in;

   // Output register.
   logic             out_acc_ff, out_acc_in;
   logic [VAL_W-1:0] out_bb_ff, out_bb_in;
   logic [VAL_W-1:0] out_bl_ff, out_bl_in;
   logic [VAL_W-1:0] out_wb_ff, out_wb_in;
   logic [VAL_W-1:0] out_wl_ff, out_wl_in;

   // Derived values.
   logic [VAL_W-1:0]        t_eff;
   logic [CNT_W-1:0]        t5;
   logic [CNT_W-1:0]        t1;
   logic [WINDOW_SLOTS-1:0] slot_mask;
   logic [WINDOW_SLOTS-1:0] win_masked;
   logic [CNT_W-1:0]        sum_c;
   logic [VAL_W-1:0]        first_c;
   logic [VAL_W-1:0]        last_c;
   logic [CNT_W-1:0]        span_c;
   logic [SEQ_W:0]          seq_diff;
   logic [SEQ_W-1:0]        gap;
   logic                    csr_write;

   // Shared comparator.
   op_type   op_a, op_b, op_c, op_d;
   prod_type prod_l, prod_r;
   logic     cmp_ge, cmp_gt;

   assign t_eff      = (window_t_ff > T_CAP) ? T_CAP : window_t_ff;
   assign t5         = {1'b0, t_eff};
   assign t1         = t5 + 5'd1;
   assign win_masked = win_ff & slot_mask;
   assign seq_diff   = {1'b0, seq_ff} - {1'b0, last_seq_ff};
   assign gap        = seq_diff[SEQ_W-1:0] - 32'd1;
   assign span_c     = {1'b0, last_c} - {1'b0, first_c} + 5'd1;
   // At most T+1 slots are counted, so the count fits in five bits.
   assign sum_c      = CNT_W'($countones(win_masked));

   always_comb begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         slot_mask[i] = (i <= int'(t_eff));
      end
   end

   // Lowest and highest erased slot within the active window.
   always_comb begin
      first_c = '0;
      last_c  = '0;
      for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
         if (win_masked[i]) begin
            first_c = VAL_W'(i);
         end
      end
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         if (win_masked[i]) begin
            last_c = VAL_W'(i);
         end
      end
   end

   // Operand selection for the shared cross-multiply comparator.
   always_comb begin
      logic [CNT_W-1:0] mbs;
      logic [CNT_W-1:0] mbp;
      mbs  = (sum_ff > {1'b0, wb_ff}) ? sum_ff : {1'b0, wb_ff};
      mbp  = (span_ff > {1'b0, wb_ff}) ? span_ff : {1'b0, wb_ff};
      op_a = '0;
      op_b = '0;
      op_c = '0;
      op_d = '0;
      case (state_ff)
         ST_UPD: begin
            op_a = op_of(t1) - op_of({1'b0, wn_ff});
            op_b = op_of(t1) - op_of(sum_ff) + op_of(mbs);
            op_c = op_of(t1) - op_of(sum_ff);
            op_d = op_of(t1) - op_of({1'b0, wn_ff}) + op_of(mbp);
         end
         ST_LIMIT: begin
            op_a = op_of(t1) - op_of({1'b0, max_loss_ff});
            op_b = op_of(t1) - op_of({1'b0, wn_ff}) + op_of({1'b0, wb_ff});
            op_c = op_of(t1) - op_of({1'b0, wn_ff});
            op_d = op_of(t1);
         end
         ST_BEST: begin
            op_a = op_of(t1) - op_of({1'b0, best_loss_ff});
            op_b = op_of(t1) - op_of({1'b0, loss_est_ff}) + op_of({1'b0, burst_est_ff});
            op_c = op_of(t1) - op_of({1'b0, loss_est_ff});
            op_d = op_of(t1) - op_of({1'b0, best_loss_ff}) + op_of({1'b0, best_burst_ff});
         end
         ST_MDS: begin
            op_a = op_of(t5) - op_of({1'b0, best_loss_ff});
            op_b = op_of(t1) - op_of({1'b0, best_loss_ff}) + op_of({1'b0, best_burst_ff});
            op_c = op_of(t1);
            op_d = op_of(t1) - op_of({1'b0, best_loss_ff});
         end
         default: begin
         end
      endcase
   end

   assign prod_l = prod_type'(op_a) * prod_type'(op_b);
   assign prod_r = prod_type'(op_c) * prod_type'(op_d);
   assign cmp_ge = (prod_l >= prod_r);
   assign cmp_gt = (prod_l > prod_r);

   // Configuration port: writes complete in the access phase, no wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_index_type'(paddr[2]))
         REG_WINDOW_T:     prdata = {{(CSR_DATA_W-VAL_W){1'b0}}, window_t_ff};
         REG_ADAPTIVE_MDS: prdata = {{(CSR_DATA_W-1){1'b0}}, adaptive_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      window_t_in = window_t_ff;
      adaptive_in = adaptive_ff;
      if (csr_write) begin
         unique case (csr_index_type'(paddr[2]))
            REG_WINDOW_T:     window_t_in = pwdata[VAL_W-1:0];
            REG_ADAPTIVE_MDS: adaptive_in = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.accepted   = out_acc_ff;
   assign rsp_if.best_burst = out_bb_ff;
   assign rsp_if.best_loss  = out_bl_ff;
   assign rsp_if.work_burst = out_wb_ff;
   assign rsp_if.work_loss  = out_wl_ff;

   // Sequencer: next state and datapath updates.
   always_comb begin
      logic [CNT_W-1:0] erasures;
      logic             erased;
      logic [VAL_W-1:0] nb;
      logic [VAL_W-1:0] nn;

      state_in      = state_ff;
      started_in    = started_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      win_in        = win_ff;
      burst_est_in  = burst_est_ff;
      loss_est_in   = loss_est_ff;
      max_loss_in   = max_loss_ff;
      best_burst_in = best_burst_ff;
      best_loss_in  = best_loss_ff;
      last_seq_in   = last_seq_ff;
      func_in       = func_ff;
      seq_in        = seq_ff;
      acc_in        = acc_ff;
      steps_in      = steps_ff;
      sum_in        = sum_ff;
      span_in       = span_ff;
      wb_in         = wb_ff;
      wn_in         = wn_ff;
      out_acc_in    = out_acc_ff;
      out_bb_in     = out_bb_ff;
      out_bl_in     = out_bl_ff;
      out_wb_in     = out_wb_ff;
      out_wl_in     = out_wl_ff;
      erasures      = '0;
      erased        = 1'b0;
      nb            = wb_ff;
      nn            = wn_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               func_in  = req_if.func;
               seq_in   = req_if.seq_number;
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            acc_in = 1'b0;
            if (func_ff) begin
               best_burst_in = burst_est_ff;
               best_loss_in  = loss_est_ff;
               burst_est_in  = '0;
               loss_est_in   = '0;
               max_loss_in   = '0;
               win_in        = '0;
               state_in      = adaptive_ff ? ST_MDS : ST_FINISH;
            end else if (t_eff == '0) begin
               state_in = ST_FINISH;
            end else if (started_ff && (seq_diff[SEQ_W] || seq_diff == '0)) begin
               // Out-of-order or repeated number.
               state_in = ST_FINISH;
            end else begin
               if (started_ff) begin
                  erasures = (gap > {{(SEQ_W-CNT_W){1'b0}}, t1}) ? t1 : gap[CNT_W-1:0];
               end
               started_in  = 1'b1;
               last_seq_in = seq_ff;
               acc_in      = 1'b1;
               steps_in    = erasures + 5'd1;
               state_in    = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // The final step of a transaction shifts in the received packet.
            erased = (steps_ff != 5'd1);
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
               if (i == 0) begin
                  win_in[i] = erased;
               end else if (i <= int'(t_eff)) begin
                  win_in[i] = win_ff[i-1];
               end
            end
            state_in = ST_STATS;
         end

         ST_STATS: begin
            if (sum_c == t1 || sum_c == '0) begin
               steps_in = steps_ff - 5'd1;
               state_in = (steps_ff == 5'd1) ? ST_BEST : ST_SHIFT;
            end else begin
               wb_in   = (burst_est_ff == '0) ? VAL_W'(1) : burst_est_ff;
               wn_in   = (loss_est_ff == '0) ? VAL_W'(1) : loss_est_ff;
               sum_in  = sum_c;
               span_in = span_c;
               if (sum_c > {1'b0, max_loss_ff}) begin
                  max_loss_in = sum_c[VAL_W-1:0];
               end
               state_in = ST_UPD;
            end
         end

         ST_UPD: begin
            if (span_ff == t1) begin
               if (sum_ff > {1'b0, wn_ff}) begin
                  nn = sum_ff[VAL_W-1:0];
                  nb = sum_ff[VAL_W-1:0];
               end
            end else if (cmp_ge) begin
               if (span_ff > {1'b0, wb_ff}) begin
                  nb = span_ff[VAL_W-1:0];
                  nn = span_ff[VAL_W-1:0];
               end
            end else begin
               if (sum_ff > {1'b0, wn_ff}) begin
                  nn = sum_ff[VAL_W-1:0];
                  nb = sum_ff[VAL_W-1:0];
               end
               if (nn > nb) begin
                  nb = nn;
               end
            end
            wb_in    = nb;
            wn_in    = nn;
            state_in = ST_LIMIT;
         end

         ST_LIMIT: begin
            if (cmp_gt) begin
               nb = max_loss_ff;
               nn = max_loss_ff;
            end
            burst_est_in = nb;
            loss_est_in  = nn;
            steps_in     = steps_ff - 5'd1;
            state_in     = (steps_ff == 5'd1) ? ST_BEST : ST_SHIFT;
         end

         ST_BEST: begin
            if (cmp_ge) begin
               best_burst_in = burst_est_ff;
               best_loss_in  = loss_est_ff;
            end
            state_in = adaptive_ff ? ST_MDS : ST_FINISH;
         end

         ST_MDS: begin
            // One comparator pass per raise of the loss value.
            if (best_burst_ff > best_loss_ff) begin
               if (best_loss_ff < VAL_MAX && cmp_gt) begin
                  best_loss_in = best_loss_ff + VAL_W'(1);
               end else begin
                  best_burst_in = best_loss_ff;
                  state_in      = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_acc_in   = acc_ff;
               out_bb_in    = best_burst_ff;
               out_bl_in    = best_loss_ff;
               out_wb_in    = burst_est_ff;
               out_wl_in    = loss_est_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and estimator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         window_t_ff   <= '0;
         adaptive_ff   <= 1'b0;
         win_ff        <= '0;
         burst_est_ff  <= '0;
         loss_est_ff   <= '0;
         max_loss_ff   <= '0;
         best_burst_ff <= '0;
         best_loss_ff  <= '0;
         last_seq_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
         window_t_ff   <= window_t_in;
         adaptive_ff   <= adaptive_in;
         win_ff        <= win_in;
         burst_est_ff  <= burst_est_in;
         loss_est_ff   <= loss_est_in;
         max_loss_ff   <= max_loss_in;
         best_burst_ff <= best_burst_in;
         best_loss_ff  <= best_loss_in;
         last_seq_ff   <= last_seq_in;
      end
   end

   // Working values and output payload.
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      seq_ff     <= seq_in;
      acc_ff     <= acc_in;
      steps_ff   <= steps_in;
      sum_ff     <= sum_in;
      span_ff    <= span_in;
      wb_ff      <= wb_in;
      wn_ff      <= wn_in;
      out_acc_ff <= out_acc_in;
      out_bb_ff  <= out_bb_in;
      out_bl_ff  <= out_bl_in;
      out_wb_ff  <= out_wb_in;
      out_wl_ff  <= out_wl_in;
   end

   // Window steps always run with at least one step left.
   `EBPE_ASSERT_IMP(a_steps_live, (state_ff == ST_SHIFT || state_ff == ST_STATS || state_ff == ST_UPD || state_ff == ST_LIMIT), (steps_ff != '0), "window step with no step left")

   // A transaction reported as accepted implies a packet has been seen.
   `EBPE_ASSERT_IMP(a_acc_started, (rsp_valid_ff && out_acc_ff), started_ff, "accepted result before any packet")

   // Leaving the MDS loop always leaves an equal or loss-heavy best pair.
   `EBPE_ASSERT_IMP(a_mds_result, (state_ff == ST_FINISH && $past(state_ff) == ST_MDS), (best_burst_ff <= best_loss_ff), "MDS rule left burst above loss")

   // Once a packet has been taken the started flag never drops.
   `EBPE_ASSERT_NXT(a_started_hold, started_ff, started_ff, "started flag cleared")

endmodule
